/* sv/nalt_pkg.sv */
// Package for the node address learning table.
// Holds table sizing, request/status codes and controller-datapath structs.
// No dependencies.
package nalt_pkg;

  // Table sizing
  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Field widths
  localparam int KEY_W    = 64;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;

  // Broadcast identifier
  localparam logic [KEY_W-1:0] BCAST_ID = {KEY_W{1'b1}};

  // Request codes
  localparam logic FUNC_LEARN  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BCAST    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new request, restart the scan
    logic scan;    // walk the table one slot per cycle
    logic decide;  // apply the update and register the result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;  // last slot compared this cycle
    logic out_busy;   // result register occupied and not taken this cycle
  } dp_stat_t;

endpackage

/* sv/nalt_ctrl.sv */
// Controller for the node address learning table.
// Sequences load, table scan and decide steps; depends on nalt_pkg.
module nalt_ctrl import nalt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // hold until the result register frees up
        if (!stat.out_busy) begin
          cmd.decide = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/nalt_dp.sv */
// Datapath for the node address learning table.
// Holds the key/address memories, valid bits, scan compare and result register;
// depends on nalt_pkg.
module nalt_dp import nalt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic                in_func,
  input  logic [KEY_W-1:0]    in_node_id,
  input  logic [ADDR_W-1:0]   in_ip_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_hit,
  output logic [ADDR_W-1:0]   out_found_addr
);

  // Table storage
  logic [KEY_W-1:0]         key_mem  [TABLE_ENTRIES];
  logic [ADDR_W-1:0]        addr_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  // Captured request
  logic              func_r;
  logic [KEY_W-1:0]  key_r;
  logic [ADDR_W-1:0] addr_r;

  // Scan pipeline
  logic [IDX_W-1:0]  rd_idx_r;
  logic              issued_all_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              cmp_vld_r;
  logic              issue;

  // Scan trackers
  logic              match_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [ADDR_W-1:0] match_addr_r;
  logic              free_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              hit_now;
  logic              free_now;

  // Result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic                hit_r;
  logic [ADDR_W-1:0]   found_r;

  // Decide logic
  logic                wr_addr_en;
  logic                wr_key_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [STATUS_W-1:0] status_nxt;
  logic                hit_nxt;
  logic [ADDR_W-1:0]   found_nxt;

  assign issue    = cmd.scan && !issued_all_r;
  assign hit_now  = cmp_vld_r && valid_r[cmp_idx_r] && (rd_key_r == key_r);
  assign free_now = cmp_vld_r && !valid_r[cmp_idx_r];

  assign stat.scan_done = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  assign stat.out_busy  = out_valid_r && !out_ready;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= in_node_id;
      addr_r <= in_ip_addr;
    end
  end

  // Advance the read address and compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r     <= '0;
      issued_all_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
    end else if (cmd.load) begin
      rd_idx_r     <= '0;
      issued_all_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (issue) begin
        cmp_idx_r <= rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          issued_all_r <= 1'b1;
        end else begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
      end
    end
  end

  // Registered memory read
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_key_r  <= key_mem[rd_idx_r];
      rd_addr_r <= addr_mem[rd_idx_r];
    end
  end

  // Track the first match and the lowest free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (cmd.load) begin
      match_r <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      if (hit_now && !match_r) begin
        match_r      <= 1'b1;
        match_idx_r  <= cmp_idx_r;
        match_addr_r <= rd_addr_r;
      end
      if (free_now && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
    end
  end

  // Work out the update and the result
  always_comb begin
    wr_addr_en = 1'b0;
    wr_key_en  = 1'b0;
    wr_idx     = match_idx_r;
    status_nxt = ST_MISS;
    hit_nxt    = 1'b0;
    found_nxt  = '0;
    priority if (key_r == BCAST_ID) begin
      status_nxt = ST_BCAST;
    end else if (func_r == FUNC_LEARN) begin
      priority if (match_r) begin
        wr_addr_en = cmd.decide;
        status_nxt = ST_OK;
      end else if (free_r) begin
        wr_addr_en = cmd.decide;
        wr_key_en  = cmd.decide;
        wr_idx     = free_idx_r;
        status_nxt = ST_INSERTED;
      end else begin
        status_nxt = ST_FULL;
      end
    end else begin
      if (match_r) begin
        status_nxt = ST_OK;
        hit_nxt    = 1'b1;
        found_nxt  = match_addr_r;
      end
    end
  end

  // Memory write
  always_ff @(posedge clk) begin
    if (wr_addr_en) begin
      addr_mem[wr_idx] <= addr_r;
    end
    if (wr_key_en) begin
      key_mem[wr_idx] <= key_r;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_key_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.decide) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      status_r <= status_nxt;
      hit_r    <= hit_nxt;
      found_r  <= found_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_hit        = hit_r;
  assign out_found_addr = found_r;

endmodule

/* sv/node_address_learning_table.sv */
// Node address learning table: maps 64-bit node identifiers to IPv4 addresses.
// Input channel in_*: in_func (0 learn, 1 look up), in_node_id, in_ip_addr.
// Result channel out_*: out_status, out_hit, out_found_addr, one per request.
// Learn refreshes a matching entry or fills the lowest free slot; the all-ones
// identifier is ignored. Lookup reports hit and the stored address.
// From request accept to result valid, the scan walks one slot per cycle
// through the single read port of the key/address memory, the read data is
// registered, and a decide step then loads the result register.
// in_ready is high only while the controller is idle, so one request is in
// flight at a time: a new request is not taken until the last one is decided.
// The result register decouples the two sides: a new request is accepted while
// a result still waits. If the receiver stalls, the next request finishes its
// scan and then holds until the result register is taken.
// Reset (synchronous, active low): all valid bits clear, table reads as empty.
// Depends on nalt_pkg, nalt_ctrl and nalt_dp.
module node_address_learning_table import nalt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [KEY_W-1:0]    in_node_id,
  input  logic [ADDR_W-1:0]   in_ip_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_hit,
  output logic [ADDR_W-1:0]   out_found_addr
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nalt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nalt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_func        (in_func),
    .in_node_id     (in_node_id),
    .in_ip_addr     (in_ip_addr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_hit        (out_hit),
    .out_found_addr (out_found_addr)
  );

endmodule

/* sv/nalt_checker.sv */
// Port-level checker for the node address learning table, bound to the top.
// Depends on nalt_pkg.
module nalt_checker import nalt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_hit,
  input logic [ADDR_W-1:0]   out_found_addr
);

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped or changed while stalled");

  // One request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A hit always reports found
  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_OK)
    else $error("hit with a status other than found");

  // A miss or learn returns address zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_addr == '0)
    else $error("nonzero address without a hit");

endmodule

bind node_address_learning_table nalt_checker u_nalt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_hit        (out_hit),
  .out_found_addr (out_found_addr)
);

/* bench/node_address_learning_table_test.sv */
// Testbench for node_address_learning_table: opening table of requests, then random traffic.
// Every result is checked in order against a fixed reply or a behavioral bench table.
// Depends on nalt_pkg and the node_address_learning_table RTL.
`timescale 1ns / 1ps

module node_address_learning_table_test;
  import nalt_pkg::*;

  localparam int RANDOM_REQUESTS = 1200;
  localparam int RESET_CYCLES    = 12;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = TABLE_ENTRIES + 10;
  localparam int PAUSE_AT        = 400;
  localparam int PAUSE_CYCLES    = 200;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [ADDR_W-1:0]   found_addr;
  } table_reply_t;

  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  node_id;
    logic [ADDR_W-1:0] ip_addr;
    logic              fixed;
    table_reply_t      reply;
  } plan_row_t;

  localparam table_reply_t ANY_REPLY = '0;

  // Opening requests; fixed replies only where they are obvious
  localparam int OPENING_ROWS = 23;
  localparam plan_row_t OPENING_PLAN [OPENING_ROWS] = '{
    // empty table after reset
    '{FUNC_LOOKUP, 64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, '{ST_MISS, 1'b0, 32'h0}},
    '{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_BCAST, 1'b0, 32'h0}},
    '{FUNC_LEARN,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_BCAST, 1'b0, 32'h0}},
    '{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_BCAST, 1'b0, 32'h0}},
    // insert, refresh and look up the all-zero identifier
    '{FUNC_LEARN,  64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, '{ST_INSERTED, 1'b0, 32'h0}},
    '{FUNC_LOOKUP, 64'h0000_0000_0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 1'b1, 32'h0}},
    '{FUNC_LEARN,  64'h0000_0000_0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 1'b0, 32'h0}},
    '{FUNC_LOOKUP, 64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1,
      '{ST_OK, 1'b1, 32'hFFFF_FFFF}},
    // fill the remaining slots
    '{FUNC_LEARN,  64'hFFFF_FFFF_FFFF_FFFE, 32'h8000_0001, 1'b0, ANY_REPLY},
    '{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0000_0000, 1'b0, ANY_REPLY},
    '{FUNC_LEARN,  64'h8000_0000_0000_0000, 32'h0000_0001, 1'b0, ANY_REPLY},
    '{FUNC_LEARN,  64'h0000_0000_0000_0001, 32'h7FFF_FFFF, 1'b0, ANY_REPLY},
    '{FUNC_LEARN,  64'h7FFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A, 1'b0, ANY_REPLY},
    '{FUNC_LEARN,  64'h0123_4567_89AB_CDEF, 32'h0A00_0001, 1'b0, ANY_REPLY},
    '{FUNC_LEARN,  64'hFEDC_BA98_7654_3210, 32'hC0A8_0101, 1'b0, ANY_REPLY},
    '{FUNC_LEARN,  64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, ANY_REPLY},
    // full table: new identifier refused, refresh still works
    '{FUNC_LEARN,  64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b1, '{ST_FULL, 1'b0, 32'h0}},
    '{FUNC_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0000_0000, 1'b1, '{ST_MISS, 1'b0, 32'h0}},
    '{FUNC_LEARN,  64'h8000_0000_0000_0000, 32'h1234_5678, 1'b0, ANY_REPLY},
    '{FUNC_LOOKUP, 64'h8000_0000_0000_0000, 32'h0000_0000, 1'b0, ANY_REPLY},
    '{FUNC_LEARN,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_BCAST, 1'b0, 32'h0}},
    '{FUNC_LOOKUP, 64'h0000_0000_0000_0002, 32'h0000_0000, 1'b1, '{ST_MISS, 1'b0, 32'h0}},
    '{FUNC_LOOKUP, 64'h5555_5555_5555_5555, 32'h0000_0000, 1'b0, ANY_REPLY}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_func;
  logic [KEY_W-1:0]    in_node_id;
  logic [ADDR_W-1:0]   in_ip_addr;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic                out_hit;
  logic [ADDR_W-1:0]   out_found_addr;

  // Bench copy of the table
  logic [KEY_W-1:0]  known_id  [TABLE_ENTRIES];
  logic [ADDR_W-1:0] known_ip  [TABLE_ENTRIES];
  bit                slot_used [TABLE_ENTRIES];

  table_reply_t due_replies [$];
  int unsigned  mismatches    = 0;
  int unsigned  requests_sent = 0;
  int unsigned  idle_cycles   = 0;
  bit           tx_steady     = 0;
  logic         rx_pause;

  node_address_learning_table u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_node_id    (in_node_id),
    .in_ip_addr    (in_ip_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_hit       (out_hit),
    .out_found_addr(out_found_addr)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one request to the bench table and return the reply it should give
  function automatic table_reply_t resolve_request(input logic func,
                                                   input logic [KEY_W-1:0] id,
                                                   input logic [ADDR_W-1:0] ip);
    table_reply_t r;
    int match;
    int spare;
    r = '{status: ST_MISS, hit: 1'b0, found_addr: '0};
    match = -1;
    spare = -1;
    // walk downward so the lowest slot wins
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && known_id[i] == id) match = i;
      if (!slot_used[i]) spare = i;
    end
    if (id == BCAST_ID) begin
      r.status = ST_BCAST;
    end else if (func == FUNC_LEARN) begin
      if (match >= 0) begin
        known_ip[match] = ip;
        r.status = ST_OK;
      end else if (spare >= 0) begin
        known_id[spare]  = id;
        known_ip[spare]  = ip;
        slot_used[spare] = 1'b1;
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_FULL;
      end
    end else if (match >= 0) begin
      r.status     = ST_OK;
      r.hit        = 1'b1;
      r.found_addr = known_ip[match];
    end
    return r;
  endfunction

  // Pick an identifier that the table currently holds, or a random one if it is empty
  function automatic logic [KEY_W-1:0] pick_known_id();
    int i;
    i = $urandom_range(0, TABLE_ENTRIES - 1);
    repeat (TABLE_ENTRIES) begin
      if (slot_used[i]) return known_id[i];
      i = (i + 1) % TABLE_ENTRIES;
    end
    return {$urandom, $urandom};
  endfunction

  // Offer one request after a random gap, or none in steady mode, and record its expected reply
  task automatic offer_request(input logic func, input logic [KEY_W-1:0] id,
                               input logic [ADDR_W-1:0] ip, input logic fixed,
                               input table_reply_t fixed_reply);
    int unsigned gap;
    table_reply_t predicted;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= func;
    in_node_id <= id;
    in_ip_addr <= ip;
    do @(posedge clk); while (!in_ready);
    predicted = resolve_request(func, id, ip);
    due_replies.push_back(fixed ? fixed_reply : predicted);
    requests_sent++;
    if (requests_sent % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
  endtask

  // Request source: opening plan, then random traffic, then drain
  initial begin : request_source
    int unsigned       pick;
    logic [KEY_W-1:0]  id;
    logic [ADDR_W-1:0] ip;
    logic              func;
    in_valid   <= 1'b0;
    in_func    <= FUNC_LEARN;
    in_node_id <= '0;
    in_ip_addr <= '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      known_id[i]  = '0;
      known_ip[i]  = '0;
      slot_used[i] = 1'b0;
    end
    wait (rst_n === 1'b1);
    @(posedge clk);

    foreach (OPENING_PLAN[i]) begin
      offer_request(OPENING_PLAN[i].func, OPENING_PLAN[i].node_id, OPENING_PLAN[i].ip_addr,
                    OPENING_PLAN[i].fixed, OPENING_PLAN[i].reply);
    end

    // Mostly known identifiers, so refresh and hit paths see most traffic
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      ip   = $urandom;
      func = 1'($urandom_range(0, 1));
      if (pick < 35) begin
        func = FUNC_LEARN;
        id   = pick_known_id();
      end else if (pick < 65) begin
        func = FUNC_LOOKUP;
        id   = pick_known_id();
      end else if (pick < 75) begin
        func = FUNC_LOOKUP;
        id   = {$urandom, $urandom};
      end else if (pick < 83) begin
        func = FUNC_LEARN;
        id   = {$urandom, $urandom};
      end else if (pick < 92) begin
        // near miss: one bit off a stored identifier
        id = pick_known_id() ^ (64'd1 << $urandom_range(0, KEY_W - 1));
      end else begin
        id = BCAST_ID;
      end
      offer_request(func, id, ip, 1'b0, ANY_REPLY);
    end
    in_valid <= 1'b0;

    while (due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hold the result side off for a long stretch once traffic is under way
  initial begin : result_pause
    rx_pause <= 1'b0;
    wait (requests_sent >= PAUSE_AT);
    rx_pause <= 1'b1;
    repeat (PAUSE_CYCLES) @(posedge clk);
    rx_pause <= 1'b0;
  end

  // Result sink: take results with random stalls and check them in order
  initial begin : result_sink
    int unsigned  stall_left;
    int unsigned  taken;
    bit           steady;
    table_reply_t want;
    stall_left = 0;
    taken      = 0;
    steady     = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with no request pending: status %0d hit %0b addr %h",
                     $realtime, out_status, out_hit, out_found_addr);
        end else begin
          want = due_replies.pop_front();
          if (out_status !== want.status || out_hit !== want.hit ||
              out_found_addr !== want.found_addr) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch: status %0d/%0d hit %0b/%0b addr %h/%h (exp/got)",
                       $realtime, want.status, out_status, want.hit, out_hit,
                       want.found_addr, out_found_addr);
          end
        end
        taken++;
        if (taken % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        stall_left = steady ? 0 : $urandom_range(0, 6);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0) && !rx_pause;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
